/* rtl/core/subtitle_rle_run_decoder_top_defines.svh */
// Assertion helpers used by the decoder's output queue.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef SUBTITLE_RLE_RUN_DECODER_TOP_DEFINES_SVH
`define SUBTITLE_RLE_RUN_DECODER_TOP_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SRD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srd assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define SRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srd assertion failed");

`endif

/* rtl/core/srd_pkg.sv */
package srd_pkg;

    // Input item kinds, carried on s_tuser
    localparam logic CMD_HEADER = 1'b0;
    localparam logic CMD_DATA   = 1'b1;

    // Code extension limits for one, two and three nibbles
    localparam logic [9:0] LIMIT_ONE   = 10'd4;
    localparam logic [9:0] LIMIT_TWO   = 10'd16;
    localparam logic [9:0] LIMIT_THREE = 10'd64;

    // Color offset added to the two-bit color code
    localparam logic [2:0] COLOR_OFFSET = 3'd3;

    // Result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Decoder state carried from nibble to nibble
    typedef struct packed {
        logic [5:0]  acc;
        logic [1:0]  nib_cnt;
        logic [15:0] column;
        logic [16:0] row;
        logic        odd_field;
        logic        finished;
        logic [15:0] line_width;
        logic [15:0] line_count;
    } srd_state_t;

    // One decoded run
    typedef struct packed {
        logic        last;
        logic        line_end;
        logic [15:0] run_length;
        logic [15:0] run_row;
        logic [15:0] run_x;
        logic [2:0]  pixel_value;
    } srd_run_t;

endpackage

/* rtl/core/srd_nib_step.sv */
module srd_nib_step
    import srd_pkg::*;
(
    input  srd_state_t st_in,
    input  logic [3:0] nibble,
    output srd_state_t st_out,
    output logic       produced,
    output logic       eol,
    output srd_run_t   run
);

    logic [9:0]  val;
    logic [2:0]  n;
    logic        extend;
    logic        fill;
    logic [15:0] diff;
    logic [15:0] len_raw;
    logic [15:0] len;
    logic [16:0] row_inc;

    // Build the code value and decide whether to extend it
    assign val    = {st_in.acc, nibble};
    assign n      = {1'b0, st_in.nib_cnt} + 3'd1;
    assign extend = ((n == 3'd1) && (val < LIMIT_ONE))
                 || ((n == 3'd2) && (val < LIMIT_TWO))
                 || ((n == 3'd3) && (val < LIMIT_THREE));
    assign fill   = (n == 3'd4) && (val < LIMIT_ONE);

    // Clamp the run to the pixels left in the line
    assign diff    = (st_in.line_width > st_in.column) ? (st_in.line_width - st_in.column)
                                                       : 16'd0;
    assign len_raw = fill ? diff : {8'd0, val[9:2]};
    assign len     = (len_raw > diff) ? diff : len_raw;
    assign eol     = !extend && (len == diff);
    assign row_inc = st_in.row + 17'd2;

    assign produced = !extend;

    // Advance column, row and field
    always_comb
    begin
        st_out = st_in;
        if (extend)
        begin
            st_out.acc     = val[5:0];
            st_out.nib_cnt = n[1:0];
        end
        else
        begin
            st_out.acc     = 6'd0;
            st_out.nib_cnt = 2'd0;
            if (eol)
            begin
                st_out.column = 16'd0;
                st_out.row    = row_inc;
                if (row_inc >= {1'b0, st_in.line_count})
                begin
                    if (!st_in.odd_field && (st_in.line_count > 16'd1))
                    begin
                        st_out.odd_field = 1'b1;
                        st_out.row       = 17'd1;
                    end
                    else
                    begin
                        st_out.finished = 1'b1;
                    end
                end
            end
            else
            begin
                st_out.column = st_in.column + len;
            end
        end
    end

    // Form the run fields
    always_comb
    begin
        run.pixel_value = {1'b0, val[1:0]} + COLOR_OFFSET;
        run.run_x       = st_in.column;
        run.run_row     = st_in.row[15:0];
        run.run_length  = len;
        run.line_end    = eol;
        run.last        = 1'b0;
    end

endmodule

/* rtl/core/srd_core.sv */
module srd_core
    import srd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_cmd,
    input  logic [7:0]  in_byte,
    input  logic [15:0] in_width,
    input  logic [15:0] in_height,
    input  logic        room,
    output logic [1:0]  push_cnt,
    output srd_run_t    push0,
    output srd_run_t    push1
);

    logic        in_valid_reg;
    logic        in_cmd_reg;
    logic [7:0]  in_byte_reg;
    logic [15:0] in_width_reg;
    logic [15:0] in_height_reg;

    srd_state_t  state_reg;
    srd_state_t  state_next;
    srd_state_t  st1;
    srd_state_t  st2;
    logic        p1;
    logic        p2;
    logic        eol1;
    logic        eol2;
    srd_run_t    r1;
    srd_run_t    r2;
    logic        en1;
    logic        en2;
    logic        v1;
    logic        v2;
    logic        fire;

    // Process a held header at once, a held data byte once the queue can take two runs
    assign fire     = in_valid_reg && ((in_cmd_reg == CMD_HEADER) || room);
    assign in_ready = !in_valid_reg || fire;

    // Hold the input item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_cmd_reg    <= in_cmd;
            in_byte_reg   <= in_byte;
            in_width_reg  <= in_width;
            in_height_reg <= in_height;
        end
    end

    // High nibble, then low nibble unless the line or the bitmap ended
    srd_nib_step u_step_hi (
        .st_in    (state_reg),
        .nibble   (in_byte_reg[7:4]),
        .st_out   (st1),
        .produced (p1),
        .eol      (eol1),
        .run      (r1)
    );

    srd_nib_step u_step_lo (
        .st_in    (st1),
        .nibble   (in_byte_reg[3:0]),
        .st_out   (st2),
        .produced (p2),
        .eol      (eol2),
        .run      (r2)
    );

    assign en1 = (in_cmd_reg == CMD_DATA) && !state_reg.finished;
    assign en2 = en1 && !eol1 && !st1.finished;
    assign v1  = fire && en1 && p1;
    assign v2  = fire && en2 && p2;

    // Pack the runs of this byte and mark the last one
    always_comb
    begin
        push0      = v1 ? r1 : r2;
        push0.last = !(v1 && v2);
        push1      = r2;
        push1.last = 1'b1;
        push_cnt   = {1'b0, v1} + {1'b0, v2};
    end

    // Load on a header, advance on a data byte
    always_comb
    begin
        state_next = state_reg;
        if (fire)
        begin
            if (in_cmd_reg == CMD_HEADER)
            begin
                state_next.acc        = 6'd0;
                state_next.nib_cnt    = 2'd0;
                state_next.column     = 16'd0;
                state_next.row        = 17'd0;
                state_next.odd_field  = 1'b0;
                state_next.finished   = 1'b0;
                state_next.line_width = in_width_reg;
                state_next.line_count = in_height_reg;
            end
            else if (en1)
            begin
                state_next = en2 ? st2 : st1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.acc        <= 6'd0;
            state_reg.nib_cnt    <= 2'd0;
            state_reg.column     <= 16'd0;
            state_reg.row        <= 17'd0;
            state_reg.odd_field  <= 1'b0;
            state_reg.finished   <= 1'b1;
            state_reg.line_width <= 16'd0;
            state_reg.line_count <= 16'd0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/srd_out_fifo.sv */
`include "subtitle_rle_run_decoder_top_defines.svh"

module srd_out_fifo
    import srd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  push_cnt,
    input  srd_run_t    push0,
    input  srd_run_t    push1,
    output logic        room,
    output logic        out_valid,
    input  logic        out_ready,
    output srd_run_t    out_run
);

    srd_run_t             entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg;
    logic [FIFO_CW-1:0]   count_next;
    logic [FIFO_AW-1:0]   wr_ptr_inc;
    logic                 pop;

    assign out_valid  = (count_reg != '0);
    assign out_run    = entry_reg[rd_ptr_reg];
    assign pop        = out_valid && out_ready;
    assign room       = (count_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign wr_ptr_inc = wr_ptr_reg + FIFO_AW'(1);
    assign count_next = count_reg + FIFO_CW'(push_cnt) - FIFO_CW'(pop);

    // Write up to two runs per cycle
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            entry_reg[wr_ptr_inc] <= push1;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(push_cnt);
            rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(pop);
            count_reg  <= count_next;
        end
    end

    `SRD_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= FIFO_CW'(FIFO_DEPTH))
    `SRD_ASSERT_SAME(a_push_room, push_cnt != 2'd0, room)
    `SRD_ASSERT_NEXT(a_idle_stays_empty, (count_reg == '0) && (push_cnt == 2'd0),
                     count_reg == '0)

endmodule

/* rtl/core/subtitle_rle_run_decoder_top.sv */
// Subtitle bitmap run decoder.
// Slave channel: one item per header or coded byte. s_tuser is the kind
// (0 = header with width and height, 1 = data byte, high nibble first).
// A header restarts decoding; data bytes before a header or after the last
// row are dropped without results.
// Master channel: one item per decoded run, carrying color + 3, first column,
// row, clamped length; m_tuser marks the run that ends its row and m_tlast
// the last run caused by one input byte.
// A run is offered from the result queue after its byte sits in the input
// register and is decoded into the queue; the byte waits there while the queue lacks room for two runs.
// Throughput: one input item per cycle while m_tready stays high and each
// byte yields at most one run; bytes yielding two runs fill the four-entry
// result queue faster than the single master port drains it.
// Reset: queue empty, input register empty, decoder waits for a header.
// Stall: while m_tready is low the queue holds its runs; once it cannot take
// two more runs the input register holds and s_tready falls.
module subtitle_rle_run_decoder_top
    import srd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_byte[7:0], width[23:8], height[39:24]
    input  logic        s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // pixel_value[2:0], run_x[18:3], run_row[34:19],
                                   // run_length[50:35], zero fill [55:51]
    output logic        m_tuser,   // line_end
    output logic        m_tlast
);

    logic       room;
    logic [1:0] push_cnt;
    srd_run_t   push0;
    srd_run_t   push1;
    srd_run_t   out_run;

    // Decode bytes into runs
    srd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_byte   (s_tdata[7:0]),
        .in_width  (s_tdata[23:8]),
        .in_height (s_tdata[39:24]),
        .room      (room),
        .push_cnt  (push_cnt),
        .push0     (push0),
        .push1     (push1)
    );

    // Queue runs for the master side
    srd_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push0     (push0),
        .push1     (push1),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_run   (out_run)
    );

    assign m_tdata = {5'd0, out_run.run_length, out_run.run_row, out_run.run_x,
                      out_run.pixel_value};
    assign m_tuser = out_run.line_end;
    assign m_tlast = out_run.last;

endmodule
